// ===== rtl/core/sle_pkg.sv =====
// ============================================================================
// sle_pkg
// Shared types and constants of the serial console line editor.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

    localparam int unsigned LINE_DEPTH_DEF = 16;

    // Result kinds.
    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_LINE   = 2'd1;
    localparam logic [1:0] KIND_PROMPT = 2'd2;

    // Console characters.
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_LEFT  = 8'h44;
    localparam logic [7:0] CH_RIGHT = 8'h43;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;

    // Last newline seen.
    localparam logic [1:0] NL_NONE = 2'd0;
    localparam logic [1:0] NL_CR   = 2'd1;
    localparam logic [1:0] NL_LF   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEFT,
        ST_BS_HEAD,
        ST_CRLF,
        ST_PROMPT,
        ST_CHAR,
        ST_DATA,
        ST_SPACE,
        ST_FIX,
        ST_BACK
    } state_t;

    // What the memory walk in ST_DATA is doing.
    typedef enum logic [1:0] {
        LP_RIGHT,
        LP_BS,
        LP_INS,
        LP_ENTER
    } loop_t;

endpackage : sle_pkg

`default_nettype wire

// ===== rtl/core/serial_line_editor.sv =====
// ============================================================================
// serial_line_editor
// Console line editor: keeps a line in a small synchronous memory and
// turns each received byte into echo, line and prompt results.
// ============================================================================
// Flow: an accepted byte sets the state register, and the first result of
// the item is then loaded into the output register. Results leave at one
// per cycle while m_ready is high; an insert ahead of the tail pauses in
// ST_FIX for its final memory write. s_ready is high only in ST_IDLE, so a
// new byte waits until the item's final result has been issued. The walk
// over the line memory reads one entry per cycle while the output is free.
// Reset clears length, cursor and sequence state; the memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module serial_line_editor #(
    parameter int unsigned LINE_DEPTH = sle_pkg::LINE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_kind,
    output logic [7:0]      m_data,
    output logic            m_last
);
    import sle_pkg::*;

    localparam int unsigned LEN_W = $clog2(LINE_DEPTH);
    localparam logic [LEN_W:0] DEPTH_EXT = (LEN_W + 1)'(LINE_DEPTH);
    localparam logic [LEN_W-1:0] ONE = LEN_W'(1);

    state_t              state_reg, state_next;
    loop_t               mode_reg, mode_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    cur_reg, cur_next;
    logic [LEN_W-1:0]    ptr_reg, ptr_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic [LEN_W-1:0]    tail_reg, tail_next;
    logic [7:0]          carry_reg, carry_next;
    logic [1:0]          k_reg, k_next;
    logic [1:0]          esc_reg, esc_next;
    logic [1:0]          nl_reg, nl_next;

    logic [7:0]          line_mem [LINE_DEPTH];
    logic [7:0]          rd_data_reg;
    logic                mem_we;
    logic [LEN_W-1:0]    mem_waddr;
    logic [7:0]          mem_wdata;

    logic                m_valid_reg;
    logic [1:0]          m_kind_reg;
    logic [7:0]          m_data_reg;
    logic                m_last_reg;

    logic                em_valid;
    logic [1:0]          em_kind;
    logic [7:0]          em_data;
    logic                em_last;
    logic                out_free;
    logic                em_fire;

    logic                accept;
    logic                is_pair, is_esc, is_bs, is_enter, is_ins;
    logic                line_full;
    logic [LEN_W-1:0]    eff_len, eff_cur, ins_tail;

    assign out_free = !m_valid_reg || m_ready;
    assign em_fire  = em_valid && out_free;
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;

    // Byte decode, in priority order.
    assign is_pair  = ((s_rx_byte == CH_CR) && (nl_reg == NL_LF)) ||
                      ((s_rx_byte == CH_LF) && (nl_reg == NL_CR));
    assign is_esc   = !is_pair && ((s_rx_byte == CH_ESC) || (esc_reg != 2'd0));
    assign is_bs    = !is_pair && !is_esc &&
                      ((s_rx_byte == CH_DEL) || (s_rx_byte == CH_BS));
    assign is_enter = !is_pair && !is_esc && !is_bs &&
                      ((s_rx_byte == CH_CR) || (s_rx_byte == CH_LF));
    assign is_ins   = !is_pair && !is_esc && !is_bs && !is_enter;

    // A full line is thrown away before the new byte goes in.
    assign line_full = ({1'b0, len_reg} + (LEN_W + 1)'(1)) >= DEPTH_EXT;
    assign eff_len   = line_full ? '0 : len_reg;
    assign eff_cur   = line_full ? '0 : cur_reg;
    assign ins_tail  = eff_len - eff_cur;

    // Next state and sequencing registers.
    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        tail_next  = tail_reg;
        carry_next = carry_reg;
        k_next     = k_reg;
        esc_next   = esc_reg;
        nl_next    = nl_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    nl_next = NL_NONE;
                    k_next  = 2'd0;
                    if (is_esc) begin
                        if (esc_reg >= 2'd2) begin
                            esc_next = 2'd0;
                            if (s_rx_byte == CH_LEFT && cur_reg != '0) begin
                                cur_next   = cur_reg - ONE;
                                state_next = ST_LEFT;
                            end else if (s_rx_byte == CH_RIGHT && cur_reg < len_reg) begin
                                mode_next  = LP_RIGHT;
                                ptr_next   = cur_reg;
                                cnt_next   = ONE;
                                cur_next   = cur_reg + ONE;
                                state_next = ST_DATA;
                            end
                        end else begin
                            esc_next = esc_reg + 2'd1;
                        end
                    end else if (is_bs) begin
                        if (cur_reg != '0) begin
                            mode_next  = LP_BS;
                            len_next   = len_reg - ONE;
                            cur_next   = cur_reg - ONE;
                            tail_next  = len_reg - cur_reg;
                            cnt_next   = len_reg - cur_reg;
                            ptr_next   = cur_reg;
                            state_next = ST_BS_HEAD;
                        end
                    end else if (is_enter) begin
                        nl_next    = (s_rx_byte == CH_CR) ? NL_CR : NL_LF;
                        mode_next  = LP_ENTER;
                        cnt_next   = len_reg;
                        ptr_next   = '0;
                        len_next   = '0;
                        cur_next   = '0;
                        state_next = ST_CRLF;
                    end else if (is_ins) begin
                        mode_next  = LP_INS;
                        carry_next = s_rx_byte;
                        tail_next  = ins_tail;
                        cnt_next   = ins_tail;
                        ptr_next   = eff_cur;
                        len_next   = eff_len + ONE;
                        cur_next   = eff_cur + ONE;
                        state_next = ST_CHAR;
                    end
                end
            end
            ST_LEFT, ST_PROMPT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_BS_HEAD: begin
                if (out_free) begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd2) begin
                        state_next = (tail_reg == '0) ? ST_IDLE : ST_DATA;
                    end
                end
            end
            ST_CRLF: begin
                if (out_free) begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd1) begin
                        state_next = (cnt_reg == '0) ? ST_PROMPT : ST_DATA;
                    end
                end
            end
            ST_CHAR: begin
                if (out_free) begin
                    state_next = (tail_reg == '0) ? ST_IDLE : ST_DATA;
                end
            end
            ST_DATA: begin
                if (out_free) begin
                    // The next entry is read while this one leaves.
                    ptr_next = ptr_reg + ONE;
                    cnt_next = cnt_reg - ONE;
                    if (mode_reg == LP_INS) begin
                        carry_next = rd_data_reg;
                    end
                    if (cnt_reg == ONE) begin
                        case (mode_reg)
                            LP_BS:   state_next = ST_SPACE;
                            LP_INS:  state_next = ST_FIX;
                            default: state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_SPACE: begin
                if (out_free) begin
                    cnt_next   = tail_reg + ONE;
                    state_next = ST_BACK;
                end
            end
            ST_FIX: begin
                cnt_next   = tail_reg;
                state_next = ST_BACK;
            end
            ST_BACK: begin
                if (out_free) begin
                    cnt_next = cnt_reg - ONE;
                    if (cnt_reg == ONE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result beats and memory writes.
    always_comb begin
        em_valid  = 1'b0;
        em_kind   = KIND_ECHO;
        em_data   = CH_BS;
        em_last   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = carry_reg;

        case (state_reg)
            ST_IDLE: begin
                // Insert at the end of the line: no tail to move.
                if (accept && is_ins && ins_tail == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = eff_len;
                    mem_wdata = s_rx_byte;
                end
            end
            ST_LEFT: begin
                em_valid = 1'b1;
                em_last  = 1'b1;
            end
            ST_PROMPT: begin
                em_valid = 1'b1;
                em_kind  = KIND_PROMPT;
                em_data  = 8'h00;
                em_last  = 1'b1;
            end
            ST_BS_HEAD: begin
                em_valid = 1'b1;
                em_data  = (k_reg == 2'd1) ? CH_SP : CH_BS;
                em_last  = (k_reg == 2'd2) && (tail_reg == '0);
            end
            ST_CRLF: begin
                em_valid = 1'b1;
                em_data  = (k_reg == 2'd0) ? CH_CR : CH_LF;
            end
            ST_CHAR: begin
                em_valid = 1'b1;
                em_data  = carry_reg;
                em_last  = (tail_reg == '0);
            end
            ST_DATA: begin
                em_valid = 1'b1;
                em_kind  = (mode_reg == LP_ENTER) ? KIND_LINE : KIND_ECHO;
                em_data  = rd_data_reg;
                em_last  = (cnt_reg == ONE) &&
                           ((mode_reg == LP_RIGHT) || (mode_reg == LP_ENTER));
                if (out_free && mode_reg == LP_INS) begin
                    mem_we = 1'b1;
                end else if (out_free && mode_reg == LP_BS) begin
                    mem_we    = 1'b1;
                    mem_waddr = ptr_reg - ONE;
                    mem_wdata = rd_data_reg;
                end
            end
            ST_SPACE: begin
                em_valid = 1'b1;
                em_data  = CH_SP;
            end
            ST_FIX: begin
                // Last tail byte lands one place past the old end.
                mem_we = 1'b1;
            end
            ST_BACK: begin
                em_valid = 1'b1;
                em_last  = (cnt_reg == ONE);
            end
            default: begin
                em_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            cur_reg   <= '0;
            esc_reg   <= 2'd0;
            nl_reg    <= NL_NONE;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cur_reg   <= cur_next;
            esc_reg   <= esc_next;
            nl_reg    <= nl_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg  <= mode_next;
        ptr_reg   <= ptr_next;
        cnt_reg   <= cnt_next;
        tail_reg  <= tail_next;
        carry_reg <= carry_next;
        k_reg     <= k_next;
    end

    // Line memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= line_mem[ptr_next];
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (em_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (em_fire) begin
            m_kind_reg <= em_kind;
            m_data_reg <= em_data;
            m_last_reg <= em_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_data  = m_data_reg;
    assign m_last  = m_last_reg;

    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_reg <= len_reg)
        else $error("cursor beyond line length");

    a_len_in_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, len_reg} < DEPTH_EXT)
        else $error("line length reached the store depth");

    a_last_ends_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (em_fire && em_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer busy after the final beat of an item");

    a_esc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        esc_reg != 2'd3)
        else $error("escape counter overran");

endmodule : serial_line_editor

`default_nettype wire

// ===== tb/tb_serial_line_editor.sv =====
// ============================================================================
// tb_serial_line_editor
// Self-checking bench for the serial console line editor. Console bytes go
// in through a sender that idles in random bursts. A behavioral copy of the
// editor predicts every echo, line and prompt result, and a checker compares
// each result beat against the oldest prediction while the receiver stalls
// on its own random pattern.
// ============================================================================
`timescale 1ns / 1ps

module tb_serial_line_editor;

    import sle_pkg::*;

    localparam int unsigned LINE_DEPTH = LINE_DEPTH_DEF;
    localparam logic [7:0]  CH_CSI     = 8'h5b;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } console_res_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'd0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [1:0] m_kind;
    logic [7:0] m_data;
    logic       m_last;

    serial_line_editor #(
        .LINE_DEPTH(LINE_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_kind   (m_kind),
        .m_data   (m_data),
        .m_last   (m_last)
    );

    always #5 aclk = ~aclk;

    // Predicted editor state.
    logic [7:0]  line_copy [LINE_DEPTH];
    int unsigned line_len   = 0;
    int unsigned cur_pos    = 0;
    int unsigned esc_seen   = 0;
    logic [1:0]  nl_prev    = NL_NONE;

    console_res_t console_out_q [$];
    console_res_t held_res;
    bit           held_ok = 1'b0;

    int errors      = 0;
    int burst_left  = 0;
    bit sender_gaps = 1'b1;
    int stall_req   = 0;

    // Each result is held back one step so the final one of a byte can be
    // flagged as last when the byte is done.
    function automatic void emit_result(input logic [1:0] k, input logic [7:0] d);
        if (held_ok)
            console_out_q.push_back(held_res);
        held_res.kind = k;
        held_res.data = d;
        held_res.last = 1'b0;
        held_ok = 1'b1;
    endfunction

    function automatic void edit_line(input logic [7:0] ch);
        logic [1:0]  prev;
        int unsigned num;
        prev = nl_prev;
        nl_prev = NL_NONE;
        if ((ch == CH_CR && prev == NL_LF) || (ch == CH_LF && prev == NL_CR)) begin
            // Second byte of a newline pair is dropped.
        end else if (ch == CH_ESC || esc_seen > 0) begin
            if (esc_seen >= 2) begin
                if (ch == CH_LEFT) begin
                    if (line_len > 0 && cur_pos > 0) begin
                        emit_result(KIND_ECHO, CH_BS);
                        cur_pos--;
                    end
                end else if (ch == CH_RIGHT) begin
                    if (cur_pos < line_len) begin
                        emit_result(KIND_ECHO, line_copy[cur_pos]);
                        cur_pos++;
                    end
                end
                esc_seen = 0;
            end else begin
                esc_seen++;
            end
        end else if (ch == CH_DEL || ch == CH_BS) begin
            if (line_len > 0 && cur_pos > 0) begin
                emit_result(KIND_ECHO, CH_BS);
                emit_result(KIND_ECHO, CH_SP);
                emit_result(KIND_ECHO, CH_BS);
                line_len--;
                cur_pos--;
                if (cur_pos < line_len) begin
                    num = line_len - cur_pos;
                    for (int i = 0; i < num; i++)
                        emit_result(KIND_ECHO, line_copy[cur_pos + 1 + i]);
                    emit_result(KIND_ECHO, CH_SP);
                    for (int i = 0; i < num + 1; i++)
                        emit_result(KIND_ECHO, CH_BS);
                    for (int i = 0; i < num; i++)
                        line_copy[cur_pos + i] = line_copy[cur_pos + 1 + i];
                end
            end
        end else if (ch == CH_CR || ch == CH_LF) begin
            nl_prev = (ch == CH_CR) ? NL_CR : NL_LF;
            emit_result(KIND_ECHO, CH_CR);
            emit_result(KIND_ECHO, CH_LF);
            if (line_len == 0) begin
                emit_result(KIND_PROMPT, 8'd0);
            end else begin
                for (int i = 0; i < line_len; i++)
                    emit_result(KIND_LINE, line_copy[i]);
            end
            line_len = 0;
            cur_pos = 0;
        end else begin
            // A full line is thrown away before the new byte goes in.
            if (line_len + 1 >= LINE_DEPTH) begin
                line_len = 0;
                cur_pos = 0;
            end
            emit_result(KIND_ECHO, ch);
            if (cur_pos != line_len) begin
                num = line_len - cur_pos;
                for (int i = 0; i < num; i++)
                    emit_result(KIND_ECHO, line_copy[cur_pos + i]);
                for (int i = 0; i < num; i++) begin
                    line_copy[line_len - i] = line_copy[line_len - 1 - i];
                    emit_result(KIND_ECHO, CH_BS);
                end
                line_copy[cur_pos] = ch;
            end else begin
                line_copy[line_len] = ch;
            end
            line_len++;
            cur_pos++;
        end
        if (held_ok) begin
            held_res.last = 1'b1;
            console_out_q.push_back(held_res);
            held_ok = 1'b0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (sender_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 16);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                s_rx_byte <= 8'($urandom);
            end
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        edit_line(b);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic send_escape(input logic [7:0] middle, input logic [7:0] key);
        send_byte(CH_ESC);
        send_byte(middle);
        send_byte(key);
    endtask

    task automatic send_arrow(input logic [7:0] key);
        send_escape(($urandom_range(0, 3) != 0) ? CH_CSI : 8'($urandom), key);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (console_out_q.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0)
            b = 8'($urandom_range(CH_SP, CH_DEL - 1));
        else
            b = 8'($urandom);
        if (b == CH_CR || b == CH_LF || b == CH_BS || b == CH_DEL || b == CH_ESC)
            b = CH_SP;
        return b;
    endfunction

    // Fill the line to one short of the store, including the extreme byte
    // values and control bytes, then one more byte discards it.
    task automatic test_full_line();
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte(8'h80);
        send_byte(8'h01);
        send_byte(8'h7e);
        repeat (LINE_DEPTH - 6) send_byte(pick_text_byte());
        send_byte("Z");
    endtask

    task automatic test_cursor_keys();
        send_escape(CH_CSI, CH_LEFT);
        send_byte("A");
        send_escape(CH_ESC, CH_RIGHT);
        send_escape(8'h00, CH_ESC);
        send_escape(CH_CSI, CH_LEFT);
        send_byte(CH_DEL);
        send_byte(CH_BS);
    endtask

    task automatic test_enter_pairs();
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_byte(CH_CR);
    endtask

    // The receiver holds off long enough for the editor to back up into
    // its input while the sender keeps offering beats.
    task automatic test_output_stall();
        sender_gaps = 1'b0;
        stall_req = 300;
        repeat (6) send_byte(pick_text_byte());
        send_arrow(CH_LEFT);
        send_arrow(CH_LEFT);
        repeat (8) send_byte(pick_text_byte());
        send_byte(CH_BS);
        send_byte(CH_LF);
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_session(input int actions, input int enter_pct);
        int pick;
        for (int k = 0; k < actions; k++) begin
            if (k % 32 == 0)
                sender_gaps = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < enter_pct) begin
                case ($urandom_range(0, 3))
                    0: send_byte(CH_CR);
                    1: send_byte(CH_LF);
                    2: begin
                        send_byte(CH_CR);
                        send_byte(CH_LF);
                    end
                    default: begin
                        send_byte(CH_LF);
                        send_byte(CH_CR);
                    end
                endcase
            end else if (pick < enter_pct + 15) begin
                send_arrow(CH_LEFT);
            end else if (pick < enter_pct + 25) begin
                send_arrow(CH_RIGHT);
            end else if (pick < enter_pct + 35) begin
                send_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
            end else if (pick < enter_pct + 40) begin
                send_escape(8'($urandom), 8'($urandom));
            end else if (pick < enter_pct + 45) begin
                send_byte(8'($urandom));
            end else begin
                send_byte(pick_text_byte());
            end
        end
        sender_gaps = 1'b1;
    endtask

    // Receiver: a long hold-off when asked for, otherwise a random pattern
    // that is redrawn after a randomly drawn stretch.
    initial begin
        int stall_left;
        int mode;
        int mode_left;
        stall_left = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_req > 0) begin
                stall_left = stall_req;
                stall_req = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_results
        console_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (console_out_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, got kind %0d data %02h last %0b",
                         $time, m_kind, m_data, m_last);
            end else begin
                want = console_out_q.pop_front();
                if (want.kind !== m_kind || want.data !== m_data || want.last !== m_last) begin
                    errors++;
                    $display("%0t: mismatch, expected %0d/%02h/%0b, got %0d/%02h/%0b",
                             $time, want.kind, want.data, want.last, m_kind, m_data, m_last);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[serial_line_editor] ERROR");
        $finish;
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        test_full_line();
        wait_drained();
        test_cursor_keys();
        wait_drained();
        test_enter_pairs();
        wait_drained();
        test_output_stall();
        wait_drained();
        test_random_session(75, 8);
        wait_drained();
        test_random_session(45, 2);
        wait_drained();
        repeat (4 * LINE_DEPTH + 16) @(posedge aclk);
        if (errors == 0 && console_out_q.size() == 0) begin
            $display("[serial_line_editor] OK");
        end else begin
            $display("[serial_line_editor] ERROR");
        end
        $finish;
    end

endmodule
